// ----- hdl/qth_pkg.sv -----
`default_nettype none
package qth_pkg;

  // Coordinate and number format.
  localparam int CoordBits = 12;
  localparam int FracBits  = 24;
  localparam int OutBits   = 48;

  // Fixed widths of the transaction fields.
  localparam int InCoordW  = 12;
  localparam int InSizeW   = 13;

  // Internal widths, derived from the coordinate, fraction and output widths.
  localparam int DiffW     = CoordBits + 1;
  localparam int ProdW     = 2 * DiffW;
  localparam int OrW       = ProdW + 1;
  localparam int SizeW     = CoordBits + 1;
  localparam int NumW      = 3 * CoordBits + 6;
  localparam int MagW      = 3 * CoordBits + 5;
  localparam int RemW      = MagW + FracBits + 1;
  localparam int WideW     = MagW + OutBits + 1;

  // Pipeline depth: four front stages, then the divider.
  localparam int PipeFront = 4;
  localparam int DivLat    = OutBits + 2;
  localparam int PipeLen   = PipeFront + DivLat;

  typedef struct packed {
    logic [InCoordW-1:0] src_x1;
    logic [InCoordW-1:0] src_y1;
    logic [InCoordW-1:0] src_x2;
    logic [InCoordW-1:0] src_y2;
    logic [InCoordW-1:0] src_x3;
    logic [InCoordW-1:0] src_y3;
    logic [InCoordW-1:0] src_x4;
    logic [InCoordW-1:0] src_y4;
    logic [InSizeW-1:0]  out_width;
    logic [InSizeW-1:0]  out_height;
  } qth_in_t;

  typedef struct packed {
    logic signed [OutBits-1:0] h00;
    logic signed [OutBits-1:0] h01;
    logic signed [OutBits-1:0] h02;
    logic signed [OutBits-1:0] h10;
    logic signed [OutBits-1:0] h11;
    logic signed [OutBits-1:0] h12;
    logic signed [OutBits-1:0] h20;
    logic signed [OutBits-1:0] h21;
    logic signed [OutBits-1:0] h22;
    logic                      singular;
    logic                      saturated;
  } qth_out_t;

  // One division job: magnitudes and the sign of the quotient.
  typedef struct packed {
    logic [MagW-1:0] num_mag;
    logic [MagW-1:0] den_mag;
    logic            neg;
  } qth_div_op_t;

  typedef struct packed {
    logic signed [OutBits-1:0] value;
    logic                      sat;
  } qth_div_res_t;

endpackage
`default_nettype wire

// ----- hdl/qth_div.sv -----
`default_nettype none
// Pipelined rounding divider: one quotient bit per stage.
module qth_div import qth_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         en_i,
  input  wire qth_div_op_t  op_i,
  output qth_div_res_t      res_o
);

  logic [RemW-1:0]    rem_q [0:OutBits];
  logic [OutBits-1:0] quo_q [0:OutBits];
  logic [MagW-1:0]    den_q [0:OutBits];
  logic               neg_q [0:OutBits];
  logic               big_q [0:OutBits];

  logic [RemW-1:0]    rem_d;
  logic               big_d;
  qth_div_res_t       res_d;
  qth_div_res_t       res_q;

  // Dividend is num * 2^FracBits plus half the divisor, which rounds to nearest.
  always_comb begin
    rem_d = {1'b0, op_i.num_mag, {FracBits{1'b0}}} + RemW'(op_i.den_mag >> 1);
    big_d = WideW'(rem_d) >= {1'b0, op_i.den_mag, {OutBits{1'b0}}};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= rem_d;
      quo_q[0] <= '0;
      den_q[0] <= op_i.den_mag;
      neg_q[0] <= op_i.neg;
      big_q[0] <= big_d;
    end
  end

  for (genvar j = 0; j < OutBits; j++) begin : g_step
    localparam int Sh = OutBits - 1 - j;
    logic [WideW-1:0] wide_rem;
    logic [WideW-1:0] wide_den;
    logic [WideW-1:0] wide_diff;
    logic             ge;

    always_comb begin
      wide_rem  = WideW'(rem_q[j]);
      wide_den  = WideW'(den_q[j]) << Sh;
      ge        = wide_rem >= wide_den;
      wide_diff = wide_rem - wide_den;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j+1] <= ge ? wide_diff[RemW-1:0] : rem_q[j];
        quo_q[j+1] <= {quo_q[j][OutBits-2:0], ge};
        den_q[j+1] <= den_q[j];
        neg_q[j+1] <= neg_q[j];
        big_q[j+1] <= big_q[j];
      end
    end
  end

  // Clip to the signed range, then apply the sign.
  always_comb begin
    logic [OutBits-1:0] limit;
    logic [OutBits-1:0] mag;
    logic               over;
    limit = neg_q[OutBits] ? {1'b1, {(OutBits-1){1'b0}}} : {1'b0, {(OutBits-1){1'b1}}};
    over  = big_q[OutBits] || (quo_q[OutBits] > limit);
    mag   = over ? limit : quo_q[OutBits];
    res_d.value = neg_q[OutBits] ? -$signed(mag) : $signed(mag);
    res_d.sat   = over;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule
`default_nettype wire

// ----- hdl/quad_to_rect_homography.sv -----
`default_nettype none
// Perspective matrix from four corners. Each transaction carries the four corners of a
// source quadrilateral (top-left, top-right, bottom-left, bottom-right) and the size of a
// target rectangle; the result transaction carries the 3x3 matrix that maps the rectangle
// onto the quadrilateral, row-major, each entry in signed Q24.24 rounded to nearest with
// ties away from zero. An entry outside the 48-bit range is clipped and raises saturated.
// A degenerate quadrilateral or a zero width or height raises singular and returns an
// all-zero matrix. The block is a fixed pipeline of 54 stages: a new transaction can enter
// in every cycle unless the output is held off. The depth is set by the nine parallel
// dividers, which resolve one quotient bit per stage over 48 stages. When the output is
// held off, the whole pipeline freezes in place, so nothing is dropped or repeated, and
// in_ready_o falls for as long as the output stalls.
module quad_to_rect_homography import qth_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire qth_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output qth_out_t      out_data_o
);

  // Corner indices of the three points of each orientation test.
  // Entry 0 is the basis determinant, entries 1 to 3 replace one column by BL.
  localparam int PIdx [4] = '{0, 2, 0, 0};
  localparam int QIdx [4] = '{1, 1, 2, 1};
  localparam int RIdx [4] = '{3, 3, 3, 2};

  function automatic logic signed [DiffW-1:0] cdiff(logic [CoordBits-1:0] a,
                                                   logic [CoordBits-1:0] b);
    return $signed({1'b0, a}) - $signed({1'b0, b});
  endfunction

  logic                en;
  logic [PipeLen-1:0]  v_q;
  logic [PipeLen-1:1]  sing_q;

  // Stage 1: orientation products.
  logic signed [ProdW-1:0]  pa_d [4];
  logic signed [ProdW-1:0]  pb_d [4];
  logic signed [ProdW-1:0]  pa_q [4];
  logic signed [ProdW-1:0]  pb_q [4];
  logic [CoordBits-1:0]     rc_d [2][3];
  logic [CoordBits-1:0]     rc1_q [2][3];
  logic [SizeW-1:0]         w1_q;
  logic [SizeW-1:0]         h1_q;

  // Stage 2: determinants.
  logic signed [OrW-1:0]    det_q [4];
  logic [CoordBits-1:0]     rc2_q [2][3];
  logic [SizeW-1:0]         w2_q;
  logic [SizeW-1:0]         h2_q;

  // Stage 3: row products and scaled denominators.
  logic signed [NumW-1:0]   prod_d [3][3];
  logic signed [NumW-1:0]   prod_q [3][3];
  logic signed [NumW-1:0]   dw_q;
  logic signed [NumW-1:0]   dh_q;
  logic signed [NumW-1:0]   d3_q;

  // Stage 4: division jobs.
  qth_div_op_t              op_d [9];
  qth_div_op_t              op_q [9];
  qth_div_res_t             res [9];

  // The pipeline moves as a whole unless a finished result is waiting.
  assign en         = !v_q[PipeLen-1] || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[PipeLen-2:0], in_valid_i};
    end
  end

  always_comb begin
    logic [CoordBits-1:0] cx [4];
    logic [CoordBits-1:0] cy [4];
    cx[0] = in_data_i.src_x1[CoordBits-1:0];
    cx[1] = in_data_i.src_x2[CoordBits-1:0];
    cx[2] = in_data_i.src_x3[CoordBits-1:0];
    cx[3] = in_data_i.src_x4[CoordBits-1:0];
    cy[0] = in_data_i.src_y1[CoordBits-1:0];
    cy[1] = in_data_i.src_y2[CoordBits-1:0];
    cy[2] = in_data_i.src_y3[CoordBits-1:0];
    cy[3] = in_data_i.src_y4[CoordBits-1:0];
    for (int k = 0; k < 4; k++) begin
      pa_d[k] = ProdW'(cdiff(cx[QIdx[k]], cx[PIdx[k]])) *
                ProdW'(cdiff(cy[RIdx[k]], cy[PIdx[k]]));
      pb_d[k] = ProdW'(cdiff(cx[RIdx[k]], cx[PIdx[k]])) *
                ProdW'(cdiff(cy[QIdx[k]], cy[PIdx[k]]));
    end
    // Matrix rows are (x1, x2, x4) and (y1, y2, y4); the third row is all ones.
    rc_d[0][0] = cx[0];
    rc_d[0][1] = cx[1];
    rc_d[0][2] = cx[3];
    rc_d[1][0] = cy[0];
    rc_d[1][1] = cy[1];
    rc_d[1][2] = cy[3];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pa_q  <= pa_d;
      pb_q  <= pb_d;
      rc1_q <= rc_d;
      w1_q  <= in_data_i.out_width[SizeW-1:0];
      h1_q  <= in_data_i.out_height[SizeW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        det_q[k] <= OrW'(pa_q[k]) - OrW'(pb_q[k]);
      end
      rc2_q <= rc1_q;
      w2_q  <= w1_q;
      h2_q  <= h1_q;
    end
  end

  // A zero determinant or an empty rectangle makes the matrix singular; the flag rides
  // alongside the data down to the output.
  always_ff @(posedge clk_i) begin
    if (en) begin
      sing_q[1] <= (OrW'(pa_q[0]) == OrW'(pb_q[0])) || (w1_q == '0) || (h1_q == '0);
      sing_q[PipeLen-1:2] <= sing_q[PipeLen-2:1];
    end
  end

  always_comb begin
    for (int r = 0; r < 2; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_d[r][c] = NumW'($signed({1'b0, rc2_q[r][c]})) * NumW'(det_q[c+1]);
      end
    end
    for (int c = 0; c < 3; c++) begin
      prod_d[2][c] = NumW'(det_q[c+1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= prod_d;
      dw_q   <= NumW'(det_q[0]) * NumW'($signed({1'b0, w2_q}));
      dh_q   <= NumW'(det_q[0]) * NumW'($signed({1'b0, h2_q}));
      d3_q   <= NumW'(det_q[0]);
    end
  end

  // Column 0 divides by D*W, column 1 by D*H and column 2 by D.
  always_comb begin
    logic signed [NumW-1:0] num;
    logic signed [NumW-1:0] den;
    logic [NumW-1:0]        nabs;
    logic [NumW-1:0]        dabs;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        case (c)
          0: begin
            num = -(prod_q[r][0] + prod_q[r][1]);
            den = dw_q;
          end
          1: begin
            num = prod_q[r][1] + prod_q[r][2];
            den = dh_q;
          end
          default: begin
            num = prod_q[r][0];
            den = d3_q;
          end
        endcase
        nabs = num[NumW-1] ? -num : num;
        dabs = den[NumW-1] ? -den : den;
        op_d[r*3+c].num_mag = nabs[MagW-1:0];
        op_d[r*3+c].den_mag = dabs[MagW-1:0];
        op_d[r*3+c].neg     = num[NumW-1] ^ den[NumW-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op_q <= op_d;
    end
  end

  for (genvar e = 0; e < 9; e++) begin : g_div
    qth_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .op_i  (op_q[e]),
      .res_o (res[e])
    );
  end

  always_comb begin
    logic sing;
    sing = sing_q[PipeLen-1];
    out_data_o.h00       = sing ? '0 : res[0].value;
    out_data_o.h01       = sing ? '0 : res[1].value;
    out_data_o.h02       = sing ? '0 : res[2].value;
    out_data_o.h10       = sing ? '0 : res[3].value;
    out_data_o.h11       = sing ? '0 : res[4].value;
    out_data_o.h12       = sing ? '0 : res[5].value;
    out_data_o.h20       = sing ? '0 : res[6].value;
    out_data_o.h21       = sing ? '0 : res[7].value;
    out_data_o.h22       = sing ? '0 : res[8].value;
    out_data_o.singular  = sing;
    out_data_o.saturated = !sing && (res[0].sat || res[1].sat || res[2].sat ||
                                     res[3].sat || res[4].sat || res[5].sat ||
                                     res[6].sat || res[7].sat || res[8].sat);
  end

  assign out_valid_o = v_q[PipeLen-1];

`ifndef SYNTH
  // An accepted transaction always lands in the first stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v_q[0])
    else $error("accepted transaction not captured");

  // A stall freezes every valid bit in place.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> v_q == $past(v_q))
    else $error("pipeline moved during a stall");

  // A waiting result is kept until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result lost or changed");

  // A singular matrix never reports clipping.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.singular |-> !out_data_o.saturated)
    else $error("singular result flagged as saturated");
`endif

endmodule
`default_nettype wire

// ----- sim/tb_quad_to_rect_homography.sv -----
`timescale 1ns / 1ps
module tb_quad_to_rect_homography;
  import qth_pkg::*;

  // Reference matrices for every corner set that has entered the block, oldest first.
  // Each predicted matrix is computed with exact integer fractions and rounded once.
  class homography_scoreboard;
    qth_out_t matrix_q[$];
    int unsigned mismatches = 0;
    int unsigned singular_seen = 0;
    int unsigned saturated_seen = 0;
    int unsigned checked = 0;

    function automatic longint orient(longint px, longint py, longint qx, longint qy,
                                      longint rx, longint ry);
      return (qx - px) * (ry - py) - (rx - px) * (qy - py);
    endfunction

    // Rounded num/den in Q24.24, ties away from zero, clipped to 48 bits.
    function automatic logic [OutBits-1:0] to_q24(longint num, longint den, inout bit sat);
      bit neg;
      logic [127:0] mag, dmag, quo, lim;
      neg  = (num < 0) != (den < 0);
      mag  = (num < 0) ? -num : num;
      dmag = (den < 0) ? -den : den;
      quo  = ((mag << FracBits) + (dmag >> 1)) / dmag;
      lim  = neg ? (128'd1 << (OutBits - 1)) : ((128'd1 << (OutBits - 1)) - 1);
      if (quo > lim) begin
        sat = 1'b1;
        quo = lim;
      end
      return neg ? -quo[OutBits-1:0] : quo[OutBits-1:0];
    endfunction

    function void note_corners(qth_in_t c);
      longint x1, y1, x2, y2, x3, y3, x4, y4, w, h, d, d0, d1, d2;
      longint rows[3][3];
      logic [OutBits-1:0] ent[9];
      qth_out_t m;
      bit sat;
      x1 = longint'(c.src_x1[CoordBits-1:0]); y1 = longint'(c.src_y1[CoordBits-1:0]);
      x2 = longint'(c.src_x2[CoordBits-1:0]); y2 = longint'(c.src_y2[CoordBits-1:0]);
      x3 = longint'(c.src_x3[CoordBits-1:0]); y3 = longint'(c.src_y3[CoordBits-1:0]);
      x4 = longint'(c.src_x4[CoordBits-1:0]); y4 = longint'(c.src_y4[CoordBits-1:0]);
      w  = longint'(c.out_width[SizeW-1:0]);  h  = longint'(c.out_height[SizeW-1:0]);
      d  = orient(x1, y1, x2, y2, x4, y4);
      d0 = orient(x3, y3, x2, y2, x4, y4);
      d1 = orient(x1, y1, x3, y3, x4, y4);
      d2 = orient(x1, y1, x2, y2, x3, y3);
      m = '0;
      if (d == 0 || w == 0 || h == 0) begin
        m.singular = 1'b1;
      end else begin
        sat = 1'b0;
        rows[0] = '{x1, x2, x4};
        rows[1] = '{y1, y2, y4};
        rows[2] = '{1, 1, 1};
        for (int r = 0; r < 3; r++) begin
          ent[r*3]   = to_q24(-(rows[r][0] * d0 + rows[r][1] * d1), d * w, sat);
          ent[r*3+1] = to_q24(rows[r][1] * d1 + rows[r][2] * d2, d * h, sat);
          ent[r*3+2] = to_q24(rows[r][0] * d0, d, sat);
        end
        m = {ent[0], ent[1], ent[2], ent[3], ent[4], ent[5], ent[6], ent[7], ent[8],
             1'b0, sat};
      end
      matrix_q.push_back(m);
    endfunction

    function void check_matrix(qth_out_t got);
      qth_out_t want;
      string names[9] = '{"h00", "h01", "h02", "h10", "h11", "h12", "h20", "h21", "h22"};
      logic signed [OutBits-1:0] we, ge;
      if (matrix_q.size() == 0) begin
        $error("result transaction with no matrix pending");
        mismatches++;
        return;
      end
      want = matrix_q.pop_front();
      checked++;
      singular_seen += want.singular;
      saturated_seen += want.saturated;
      for (int k = 0; k < 9; k++) begin
        we = want[2 + (8 - k) * OutBits +: OutBits];
        ge = got[2 + (8 - k) * OutBits +: OutBits];
        if (we !== ge) begin
          $error("%s: expected %0d, actual %0d", names[k], we, ge);
          mismatches++;
        end
      end
      if (want.singular !== got.singular) begin
        $error("singular: expected %0b, actual %0b", want.singular, got.singular);
        mismatches++;
      end
      if (want.saturated !== got.saturated) begin
        $error("saturated: expected %0b, actual %0b", want.saturated, got.saturated);
        mismatches++;
      end
    endfunction
  endclass

  localparam int WatchdogLimit = 20000;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  qth_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  qth_out_t out_data_o;

  homography_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned quiet_cycles = 0;
  int unsigned sent = 0;

  quad_to_rect_homography dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o(out_data_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // The receiver decides its ready for the next edge on every falling edge.
  always @(negedge clk_i) begin
    out_ready_i <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  // Both handshakes are observed at the rising edge, before the block updates. The
  // watchdog counts consecutive cycles in which neither channel moves a transaction
  // while work is still outstanding.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        sb.note_corners(in_data_i);
      end
      if (out_valid_o && out_ready_i) begin
        sb.check_matrix(out_data_o);
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (!in_valid_i && sb.matrix_q.size() == 0)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Presents one transaction at a falling edge and holds it until accepted. Valid
  // stays high between back-to-back transactions and only drops for an idle gap.
  task automatic send_corners(qth_in_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = c;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_matrices();
    in_valid_i = 1'b0;
    while (sb.matrix_q.size() != 0) @(negedge clk_i);
  endtask

  function automatic qth_in_t quad(int x1, int y1, int x2, int y2, int x3, int y3,
                                   int x4, int y4, int w, int h);
    qth_in_t c;
    c.src_x1 = InCoordW'(x1); c.src_y1 = InCoordW'(y1);
    c.src_x2 = InCoordW'(x2); c.src_y2 = InCoordW'(y2);
    c.src_x3 = InCoordW'(x3); c.src_y3 = InCoordW'(y3);
    c.src_x4 = InCoordW'(x4); c.src_y4 = InCoordW'(y4);
    c.out_width = InSizeW'(w); c.out_height = InSizeW'(h);
    return c;
  endfunction

  // Mostly plausible quadrilaterals: a random rectangle with jittered corners. The
  // rest are fully random bit patterns, including sizes above 4096 and zero.
  function automatic qth_in_t random_corners();
    qth_in_t c;
    logic [127:0] bits;
    int l, t, r, b, j;
    if ($urandom_range(99) < 75) begin
      l = $urandom_range(2000); t = $urandom_range(2000);
      r = l + 1 + $urandom_range(2000); b = t + 1 + $urandom_range(2000);
      j = ($urandom_range(3) == 0) ? 1000 : 60;
      c = quad(l + $urandom_range(j), t + $urandom_range(j),
               r - $urandom_range(j), t + $urandom_range(j),
               l + $urandom_range(j), b - $urandom_range(j),
               r - $urandom_range(j), b - $urandom_range(j),
               ($urandom_range(3) == 0) ? $urandom_range(16) + 1 : $urandom_range(4096) + 1,
               ($urandom_range(3) == 0) ? $urandom_range(16) + 1 : $urandom_range(4096) + 1);
    end else begin
      bits = {$urandom, $urandom, $urandom, $urandom};
      c = bits[$bits(qth_in_t)-1:0];
    end
    return c;
  endfunction

  initial begin
    qth_in_t directed[$];
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Zero corners, all-ones corners and zero sizes are degenerate. A unit rectangle
    // on itself, maximum sizes, a collinear quad and a sliver that overflows the
    // output range cover the remaining corners of the behavior.
    directed.push_back(quad(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(quad(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 8191, 8191));
    directed.push_back(quad(0, 0, 100, 0, 0, 100, 100, 100, 100, 100));
    directed.push_back(quad(0, 0, 4095, 0, 0, 4095, 4095, 4095, 4096, 4096));
    directed.push_back(quad(0, 0, 4095, 0, 0, 4095, 4095, 4095, 8191, 1));
    directed.push_back(quad(0, 0, 4095, 0, 0, 4095, 4095, 4095, 1, 8191));
    directed.push_back(quad(10, 10, 500, 20, 30, 400, 480, 450, 0, 300));
    directed.push_back(quad(10, 10, 500, 20, 30, 400, 480, 450, 300, 0));
    directed.push_back(quad(0, 0, 1000, 1000, 3000, 10, 2000, 2000, 640, 480));
    directed.push_back(quad(0, 0, 4095, 1, 0, 4095, 4094, 0, 1, 1));
    directed.push_back(quad(0, 4095, 4095, 4095, 0, 0, 4095, 0, 1, 1));
    directed.push_back(quad(4095, 0, 0, 0, 4095, 4095, 0, 4095, 1, 1));
    directed.push_back(quad(100, 200, 3900, 150, 50, 3800, 4000, 4000, 1920, 1080));
    directed.push_back(quad(2048, 2048, 2049, 2048, 0, 4095, 2048, 2049, 4096, 4096));
    directed.push_back(quad(0, 0, 1, 0, 4095, 4095, 0, 1, 1, 1));
    directed.push_back(qth_in_t'('1));
    foreach (directed[i]) send_corners(directed[i]);
    drain_matrices();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 64 : 0;
      recv_idle_pct = (phase == 0) ? 64 : (phase == 1) ? 6 : 0;
      for (int n = 0; n < 330; n++) send_corners(random_corners());
      // Hold the sender off until the block has emptied before the next phase.
      drain_matrices();
    end

    repeat (PipeLen + 10) @(negedge clk_i);
    $display("Sent %0d corner sets; checked %0d matrices, %0d singular, %0d saturated.",
             sent, sb.checked, sb.singular_seen, sb.saturated_seen);
    $display("Idle patterns covered sender-heavy, receiver-heavy and full-rate traffic.");
    if (sb.mismatches == 0 && sb.matrix_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
